[rtl/j3se_pkg.sv]
// Shared types, constants and helpers for the coefficient bit extractor.
package j3se_pkg;

  localparam int POS_BITS   = 24;
  localparam int MAX_PAIRS  = 128;
  localparam int PIDX_W     = $clog2(MAX_PAIRS);
  localparam int PCNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int HALF_MAX   = (MAX_PAIRS - 1) / 2;
  localparam int HALF_W     = $clog2(HALF_MAX + 2);
  localparam int COEFF_W    = 11;
  localparam int MAG_W      = COEFF_W + 1;
  localparam int HDR_BITS   = 32;
  localparam int BYTE_BITS  = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] CFG_STOP_BITS   = 2'd0;
  localparam logic [1:0] CFG_STOP_CHECK  = 2'd1;
  localparam logic [1:0] CFG_COEFF_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_ERR  = 2'd1,
    KIND_HDR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_STOPS  = 4'b0010,
    PH_MSG    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [4:0] stop_bits;
    logic [7:0] stop_count_check;
    logic [6:0] coeff_limit;
  } cfg_t;

  typedef struct packed {
    logic                restart;
    logic                keep;
    logic                dbit;
    logic [PIDX_W-1:0]   pair;
    logic [POS_BITS-1:0] pos;
  } item_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [FIFO_AW:0] count;
  } fifo_stat_t;

  function automatic logic [HALF_W-1:0] half_of(input logic [6:0] coeff_limit);
    logic [6:0] h;
    h = {1'b0, coeff_limit[6:1]};
    if (int'(h) > HALF_MAX) begin
      return HALF_W'(HALF_MAX);
    end
    return HALF_W'(h);
  endfunction

  function automatic logic [PCNT_W-1:0] npairs_of(input logic [6:0] coeff_limit);
    logic [HALF_W:0] n;
    n = {half_of(coeff_limit), 1'b1};
    return PCNT_W'(n);
  endfunction

endpackage

[rtl/j3se_front.sv]
// Front end: takes coefficients, derives bit and pair, drops unused ones.
module j3se_front import j3se_pkg::*; (
  input  cfg_t                cfg,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                restart,
  input  logic [POS_BITS-1:0] position,
  input  logic [COEFF_W-1:0]  coeff_value,
  input  fifo_stat_t          q_stat,
  output logic                q_push,
  output item_t               q_item
);

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [HALF_W-1:0] half;
  logic [PCNT_W-1:0] npairs;
  logic              ignore;
  logic [PCNT_W:0]   pair_w;
  logic [PCNT_W:0]   mhalf;

  assign neg    = coeff_value[COEFF_W-1];
  assign mag    = neg ? (MAG_W'(1) << (COEFF_W - 1)) * MAG_W'(2) - {1'b0, coeff_value}
                      : {1'b0, coeff_value};
  assign half   = half_of(cfg.coeff_limit);
  assign npairs = npairs_of(cfg.coeff_limit);
  assign ignore = (mag == '0) || (mag > MAG_W'(npairs));
  assign mhalf  = (PCNT_W + 1)'(mag >> 1);

  always_comb begin
    if (mag == MAG_W'(1)) begin
      pair_w = (PCNT_W + 1)'(half);
    end else if (neg) begin
      pair_w = (PCNT_W + 1)'(half) - mhalf;
    end else begin
      pair_w = (PCNT_W + 1)'(half) + mhalf;
    end
  end

  assign in_tready      = !q_stat.full;
  assign q_push         = in_tvalid && in_tready && (restart || !ignore);
  assign q_item.restart = restart;
  assign q_item.keep    = !ignore;
  assign q_item.dbit    = (neg && mag == MAG_W'(1)) ? 1'b0 : mag[0];
  assign q_item.pair    = pair_w[PIDX_W-1:0];
  assign q_item.pos     = position;

endmodule

[rtl/j3se_fifo.sv]
// Short queue between the front end and the execution back end.
module j3se_fifo import j3se_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  item_t      din,
  input  logic       pop,
  output item_t      dout,
  output fifo_stat_t stat
);

  item_t              q_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (FIFO_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (FIFO_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= din;
    end
  end

endmodule

[rtl/j3se_back.sv]
// Back end: header, stop table and message byte assembly, with output register.
module j3se_back import j3se_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  item_t       head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output kind_t       out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_len,
  output logic        out_last
);

  logic [POS_BITS-1:0] stop_mem [MAX_PAIRS];
  logic [POS_BITS-1:0] rd_r;

  logic                stb_v_r;
  item_t               stb_r;
  logic                proceed;

  phase_t              phase_r, phase_nxt;
  logic [31:0]         hdr_r, hdr_nxt;
  logic [4:0]          bcnt_r, bcnt_nxt;
  logic [PCNT_W-1:0]   pcnt_r, pcnt_nxt;
  logic [15:0]         len_r, len_nxt;
  logic [7:0]          bsh_r, bsh_nxt;
  logic [POS_BITS-1:0] acc_r, acc_nxt;
  logic [MAX_PAIRS-1:0] svld_r, svld_nxt;
  logic [MAX_PAIRS-1:0] rch_r, rch_nxt;

  logic                mem_we;
  logic [PIDX_W-1:0]   mem_wa;
  logic [POS_BITS-1:0] mem_wd;

  logic                emit;
  kind_t               e_kind;
  logic [7:0]          e_byte;
  logic [15:0]         e_len;
  logic                e_last;

  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [7:0]          out_byte_r;
  logic [15:0]         out_len_r;
  logic                out_last_r;

  logic [PCNT_W-1:0]   npairs;
  logic [31:0]         hdr_n;
  logic [POS_BITS-1:0] acc_n;
  logic [POS_BITS-1:0] eff_stop;
  logic [7:0]          bsh_n;

  assign npairs  = npairs_of(cfg.coeff_limit);
  assign proceed = stb_v_r && (!out_valid_r || out_ready);
  assign pop     = head_valid && (!stb_v_r || proceed);

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    bcnt_nxt  = bcnt_r;
    pcnt_nxt  = pcnt_r;
    len_nxt   = len_r;
    bsh_nxt   = bsh_r;
    acc_nxt   = acc_r;
    svld_nxt  = svld_r;
    rch_nxt   = rch_r;
    mem_we    = 1'b0;
    mem_wa    = pcnt_r[PIDX_W-1:0];
    mem_wd    = '0;
    emit      = 1'b0;
    e_kind    = KIND_BYTE;
    e_byte    = '0;
    e_len     = '0;
    e_last    = 1'b0;
    hdr_n     = '0;
    acc_n     = '0;
    bsh_n     = '0;
    eff_stop  = svld_r[stb_r.pair] ? rd_r : '0;
    if (proceed) begin
      if (stb_r.restart) begin
        phase_nxt = PH_HEADER;
        hdr_nxt   = '0;
        bcnt_nxt  = '0;
        pcnt_nxt  = '0;
        len_nxt   = '0;
        bsh_nxt   = '0;
        acc_nxt   = '0;
        svld_nxt  = '0;
        rch_nxt   = '0;
      end
      if (stb_r.keep && phase_nxt != PH_DONE) begin
        if (phase_nxt == PH_HEADER) begin
          hdr_n   = {hdr_nxt[30:0], stb_r.dbit};
          hdr_nxt = hdr_n;
          if (bcnt_nxt != 5'(HDR_BITS - 1)) begin
            bcnt_nxt = bcnt_nxt + 5'd1;
          end else begin
            bcnt_nxt = '0;
            emit     = 1'b1;
            if (hdr_n[15:8] != {3'b000, cfg.stop_bits} || hdr_n[7:0] != cfg.stop_count_check) begin
              phase_nxt = PH_DONE;
              e_kind    = KIND_ERR;
            end else begin
              len_nxt  = hdr_n[31:16];
              svld_nxt = '0;
              rch_nxt  = '0;
              pcnt_nxt = '0;
              acc_nxt  = '0;
              e_kind   = KIND_HDR;
              e_len    = hdr_n[31:16];
              if (cfg.stop_bits != '0) begin
                phase_nxt = PH_STOPS;
              end else begin
                phase_nxt = (hdr_n[31:16] != '0) ? PH_MSG : PH_DONE;
              end
            end
          end
        end else begin
          if (phase_nxt == PH_STOPS && (pcnt_nxt >= npairs || cfg.stop_bits == '0)) begin
            bcnt_nxt  = '0;
            phase_nxt = (len_nxt != '0) ? PH_MSG : PH_DONE;
          end
          if (phase_nxt == PH_STOPS) begin
            acc_n    = {acc_nxt[POS_BITS-2:0], stb_r.dbit};
            mem_we   = 1'b1;
            mem_wa   = pcnt_nxt[PIDX_W-1:0];
            mem_wd   = acc_n;
            svld_nxt[pcnt_nxt[PIDX_W-1:0]] = 1'b1;
            bcnt_nxt = bcnt_nxt + 5'd1;
            if (bcnt_nxt >= cfg.stop_bits) begin
              bcnt_nxt = '0;
              acc_nxt  = '0;
              pcnt_nxt = pcnt_nxt + PCNT_W'(1);
              if (pcnt_nxt >= npairs) begin
                phase_nxt = (len_nxt != '0) ? PH_MSG : PH_DONE;
              end
            end else begin
              acc_nxt = acc_n;
            end
          end else if (phase_nxt == PH_MSG) begin
            if (rch_r[stb_r.pair]) begin
              // pair exhausted: coefficient carries nothing
            end else if (eff_stop == stb_r.pos) begin
              rch_nxt[stb_r.pair] = 1'b1;
            end else begin
              bsh_n    = {bsh_nxt[6:0], stb_r.dbit};
              bcnt_nxt = bcnt_nxt + 5'd1;
              if (bcnt_nxt == 5'(BYTE_BITS)) begin
                bcnt_nxt = '0;
                if (len_nxt != '0) begin
                  len_nxt = len_nxt - 16'd1;
                end
                if (len_nxt == '0) begin
                  phase_nxt = PH_DONE;
                end
                emit    = 1'b1;
                e_kind  = KIND_BYTE;
                e_byte  = bsh_n;
                e_last  = (len_nxt == '0);
                bsh_nxt = '0;
              end else begin
                bsh_nxt = bsh_n;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stop_mem[mem_wa] <= mem_wd;
    end
    if (pop) begin
      rd_r <= (mem_we && mem_wa == head.pair) ? mem_wd : stop_mem[head.pair];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stb_v_r     <= 1'b0;
      phase_r     <= PH_HEADER;
      hdr_r       <= '0;
      bcnt_r      <= '0;
      pcnt_r      <= '0;
      len_r       <= '0;
      bsh_r       <= '0;
      acc_r       <= '0;
      svld_r      <= '0;
      rch_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        stb_v_r <= 1'b1;
      end else if (proceed) begin
        stb_v_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      bcnt_r  <= bcnt_nxt;
      pcnt_r  <= pcnt_nxt;
      len_r   <= len_nxt;
      bsh_r   <= bsh_nxt;
      acc_r   <= acc_nxt;
      svld_r  <= svld_nxt;
      rch_r   <= rch_nxt;
      if (proceed && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      stb_r <= head;
    end
    if (proceed && emit) begin
      out_kind_r <= e_kind;
      out_byte_r <= e_byte;
      out_len_r  <= e_len;
      out_last_r <= e_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_len   = out_len_r;
  assign out_last  = out_last_r;

endmodule

[rtl/j3_stego_bit_extractor.sv]
// Top level of the coefficient bit extractor: config registers, front, queue, back.
//
// Takes one visited DCT coefficient per clock while the queue has room and returns
// header status and message bytes as they complete. Sustained rate is one
// coefficient per cycle while the output accepts, set by the single stop-table read
// per item (one registered memory port, forwarded from the write port) and the
// one-item-per-cycle back end. An accepted item passes through the queue and the
// back end's stage register into the output register; a four-entry queue decouples
// the front from the back so a stalled output only backs up the input once the
// queue is full. The stop table needs no clearing pass: per-entry valid bits make
// it read as zero after reset, restart and header acceptance. Configuration is
// taken at any time but must only change while the block is idle.
module j3_stego_bit_extractor import j3se_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[23:0], coeff_value[34:24], zero pad
  input  logic        in_tuser,   // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // byte_value[7:0], msg_length[23:8]
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t       cfg_r;
  fifo_stat_t q_stat;
  logic       q_push;
  item_t      q_item;
  logic       q_pop;
  item_t      q_head;
  kind_t      o_kind;
  logic [7:0] o_byte;
  logic [15:0] o_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_bits        <= 5'd20;
      cfg_r.stop_count_check <= 8'd0;
      cfg_r.coeff_limit      <= 7'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STOP_BITS:   cfg_r.stop_bits        <= cfg_data[4:0];
        CFG_STOP_CHECK:  cfg_r.stop_count_check <= cfg_data;
        CFG_COEFF_LIMIT: cfg_r.coeff_limit      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  j3se_front u_front (
    .cfg         (cfg_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .restart     (in_tuser),
    .position    (in_tdata[23:0]),
    .coeff_value (in_tdata[34:24]),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  j3se_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_item),
    .pop   (q_pop),
    .dout  (q_head),
    .stat  (q_stat)
  );

  j3se_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (!q_stat.empty),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (o_kind),
    .out_byte   (o_byte),
    .out_len    (o_len),
    .out_last   (out_tlast)
  );

  assign out_tdata = {o_len, o_byte};
  assign out_tuser = o_kind;

  a_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_BYTE)
    else $error("last flag on a non-byte result");

  a_hdr_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_HDR |-> out_tdata[7:0] == 8'd0)
    else $error("header result carries byte data");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERR |-> out_tdata == 24'd0 && !out_tlast)
    else $error("error result carries payload");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_tready && q_stat.count == (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("input accepted while queue full");

endmodule

[dv/tb_j3_stego_bit_extractor.sv]
// Testbench for j3_stego_bit_extractor: coefficient stream stimulus with self-checking results.
`timescale 1ns / 100ps

module tb_j3_stego_bit_extractor;
  import j3se_pkg::*;

  localparam int IDLE_PCT   = 37;
  localparam int DRAIN_WAIT = 20;
  localparam int WD_LIMIT   = 3000;
  localparam int ITEM_GOAL  = 1050;

  typedef struct packed {
    logic        restart;
    logic [23:0] pos;
    logic [10:0] coeff;
  } coeff_txn_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [15:0] msg_length;
    logic        last;
  } extract_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // position[23:0], coeff_value[34:24], zero pad
  logic        in_tuser = 1'b0; // restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // byte_value[7:0], msg_length[23:8]
  logic [1:0]  out_tuser;       // kind
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  j3_stego_bit_extractor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  coeff_txn_t   coeff_q[$];
  extract_rec_t pending_out_q[$];
  logic [23:0]  stop_list_q[$];
  int           pushed_cnt = 0;
  int           accepted_cnt = 0;
  int           real_cnt = 0;
  int           mismatch_cnt = 0;
  int           frame_budget = 0;
  int           cyc = 0;
  int           wd_cnt = 0;
  logic         burst;

  assign burst = (cyc >= 1200) && (cyc < 1700);

  // Extractor state as predicted
  logic [4:0]  cur_stop_bits;
  logic [7:0]  cur_check;
  logic [6:0]  cur_limit;
  phase_t      ex_phase;
  logic [31:0] hdr_sr;
  logic [4:0]  bit_cnt;
  logic [7:0]  pair_idx;
  logic [23:0] stop_pos [MAX_PAIRS];
  bit          pair_done [MAX_PAIRS];
  logic [15:0] bytes_left;
  logic [7:0]  byte_sr;

  function automatic void clear_extract();
    ex_phase   = PH_HEADER;
    hdr_sr     = '0;
    bit_cnt    = '0;
    pair_idx   = '0;
    bytes_left = '0;
    byte_sr    = '0;
    for (int i = 0; i < MAX_PAIRS; i++) begin
      stop_pos[i]  = '0;
      pair_done[i] = 1'b0;
    end
  endfunction

  function automatic int pair_total();
    logic [6:0] h;
    h = cur_limit >> 1;
    if (h > HALF_MAX) h = 7'(HALF_MAX);
    return 2 * h + 1;
  endfunction

  function automatic bit extract_coeff(input logic rs, input logic [23:0] pos,
                                       input logic [10:0] cv, output extract_rec_t rec);
    logic       neg;
    logic [11:0] mag;
    logic [7:0] np;
    logic [6:0] h;
    logic [7:0] pr;
    logic       b;
    rec = '{KIND_BYTE, 8'd0, 16'd0, 1'b0};
    if (rs) clear_extract();
    neg = cv[10];
    mag = neg ? (12'h800 - {1'b0, cv}) : {1'b0, cv};
    np  = 8'(pair_total());
    h   = np[7:1];
    if (mag == 12'd0 || mag > {4'd0, np}) return 1'b0;
    if (ex_phase == PH_DONE) return 1'b0;
    b = (neg && mag == 12'd1) ? 1'b0 : mag[0];
    if (mag == 12'd1) pr = {1'b0, h};
    else if (neg) pr = {1'b0, h} - mag[7:1];
    else pr = {1'b0, h} + mag[7:1];

    if (ex_phase == PH_HEADER) begin
      hdr_sr = {hdr_sr[30:0], b};
      if (bit_cnt < 5'd31) begin
        bit_cnt = bit_cnt + 5'd1;
        return 1'b0;
      end
      bit_cnt = '0;
      if (hdr_sr[15:8] != {3'b0, cur_stop_bits} || hdr_sr[7:0] != cur_check) begin
        ex_phase = PH_DONE;
        rec.kind = KIND_ERR;
        return 1'b1;
      end
      bytes_left = hdr_sr[31:16];
      for (int i = 0; i < MAX_PAIRS; i++) begin
        stop_pos[i]  = '0;
        pair_done[i] = 1'b0;
      end
      pair_idx = '0;
      if (cur_stop_bits != 5'd0) ex_phase = PH_STOPS;
      else ex_phase = (bytes_left != 16'd0) ? PH_MSG : PH_DONE;
      rec.kind       = KIND_HDR;
      rec.msg_length = bytes_left;
      return 1'b1;
    end

    // limit lowered or no stop bits: stop table is already complete
    if (ex_phase == PH_STOPS && (pair_idx >= np || cur_stop_bits == 5'd0)) begin
      bit_cnt  = '0;
      ex_phase = (bytes_left != 16'd0) ? PH_MSG : PH_DONE;
      if (ex_phase == PH_DONE) return 1'b0;
    end

    if (ex_phase == PH_STOPS) begin
      stop_pos[pair_idx] = {stop_pos[pair_idx][22:0], b};
      bit_cnt = bit_cnt + 5'd1;
      if (bit_cnt >= cur_stop_bits) begin
        bit_cnt  = '0;
        pair_idx = pair_idx + 8'd1;
        if (pair_idx >= np) ex_phase = (bytes_left != 16'd0) ? PH_MSG : PH_DONE;
      end
      return 1'b0;
    end

    if (pair_done[pr]) return 1'b0;
    if (stop_pos[pr] == pos) begin
      pair_done[pr] = 1'b1;
      return 1'b0;
    end
    byte_sr = {byte_sr[6:0], b};
    bit_cnt = bit_cnt + 5'd1;
    if (bit_cnt < 5'd8) return 1'b0;
    bit_cnt = '0;
    if (bytes_left != 16'd0) bytes_left = bytes_left - 16'd1;
    if (bytes_left == 16'd0) ex_phase = PH_DONE;
    rec = '{KIND_BYTE, byte_sr, 16'd0, bytes_left == 16'd0};
    byte_sr = '0;
    return 1'b1;
  endfunction

  // Driver
  always @(posedge clk) begin
    coeff_txn_t   nxt;
    extract_rec_t got;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accepted_cnt++;
        if (extract_coeff(in_tuser, in_tdata[23:0], in_tdata[34:24], got))
          pending_out_q.push_back(got);
      end
      if (!in_tvalid || in_tready) begin
        if (coeff_q.size() != 0 && (burst || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = coeff_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'd0, nxt.coeff, nxt.pos};
          in_tuser  <= nxt.restart;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    extract_rec_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_out_q.size() == 0) begin
          $error("unexpected transaction: kind %0d data %h", out_tuser, out_tdata);
          mismatch_cnt++;
        end else begin
          want = pending_out_q.pop_front();
          if (out_tuser !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_tuser);
            mismatch_cnt++;
          end
          if (out_tdata[7:0] !== want.byte_value) begin
            $error("byte_value: expected %h, actual %h", want.byte_value, out_tdata[7:0]);
            mismatch_cnt++;
          end
          if (out_tdata[23:8] !== want.msg_length) begin
            $error("msg_length: expected %0d, actual %0d", want.msg_length, out_tdata[23:8]);
            mismatch_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_tlast);
            mismatch_cnt++;
          end
        end
      end
      out_tready <= burst || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      wd_cnt <= 0;
    else
      wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_STOP_BITS:   cur_stop_bits = data[4:0];
      CFG_STOP_CHECK:  cur_check     = data;
      CFG_COEFF_LIMIT: cur_limit     = data[6:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input int sb, input int chk, input int lim);
    write_reg(CFG_STOP_BITS, {3'($urandom), 5'(sb)});
    write_reg(CFG_STOP_CHECK, 8'(chk));
    write_reg(CFG_COEFF_LIMIT, {1'($urandom), 7'(lim)});
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (accepted_cnt != pushed_cnt || pending_out_q.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic push_item(input bit rs, input logic [23:0] pos, input int val);
    coeff_q.push_back('{restart: rs, pos: pos, coeff: 11'(val)});
    pushed_cnt++;
  endtask

  task automatic push_bit(input bit b, input bit rs, input logic [23:0] pos);
    int np, k, v, mag;
    if (frame_budget == 0) return;
    frame_budget--;
    np = pair_total();
    // ignored coefficients: zero or beyond the limit
    if (!rs && $urandom_range(0, 99) < 8) begin
      if ($urandom_range(0, 1)) begin
        v = 0;
      end else begin
        mag = $urandom_range(np + 1, 1024);
        v = (mag == 1024 || $urandom_range(0, 1)) ? -mag : mag;
      end
      push_item(1'b0, 24'($urandom), v);
    end
    if (b) begin
      k = $urandom_range(0, (np - 1) / 2);
      v = (k == 0) ? 1 : 2 * k + 1;
    end else begin
      k = $urandom_range(0, np / 2);
      v = (k == 0) ? -1 : 2 * k;
    end
    if (k != 0 && $urandom_range(0, 1)) v = -v;
    push_item(rs, pos, v);
    real_cnt++;
  endtask

  task automatic gen_header(input int len, input bit bad);
    logic [31:0] hdr;
    stop_list_q.delete();
    hdr = {16'(len), 3'b0, cur_stop_bits, cur_check};
    if (bad) hdr[$urandom_range(0, 15)] ^= 1'b1;
    for (int i = 31; i >= 0; i--) push_bit(hdr[i], i == 31, 24'($urandom));
  endtask

  task automatic gen_stops(input int pairs);
    logic [31:0] sp;
    logic [63:0] keep;
    if (cur_stop_bits == 5'd0) return;
    keep = (64'd1 << cur_stop_bits) - 64'd1;
    for (int p = 0; p < pairs; p++) begin
      sp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
      stop_list_q.push_back(24'(sp & keep[31:0]));
      for (int i = int'(cur_stop_bits) - 1; i >= 0; i--) push_bit(sp[i], 1'b0, 24'($urandom));
    end
  endtask

  task automatic gen_msg(input int len);
    int nbits, r;
    logic [23:0] pos;
    nbits = ((len > 4) ? 4 : len) * 8 + $urandom_range(0, 12);
    for (int i = 0; i < nbits; i++) begin
      r = $urandom_range(0, 9);
      if (r < 2 && stop_list_q.size() != 0)
        pos = stop_list_q[$urandom_range(0, stop_list_q.size() - 1)];
      else if (r < 4)
        pos = 24'($urandom_range(0, 15));
      else
        pos = 24'($urandom);
      push_bit(1'($urandom), 1'b0, pos);
    end
  endtask

  task automatic gen_frame(input int len, input bit bad, input bit cut);
    frame_budget = cut ? $urandom_range(1, 40) : 32'h4000_0000;
    gen_header(len, bad);
    if (bad) begin
      for (int i = 0; i < 4; i++) push_bit(1'($urandom), 1'b0, 24'($urandom));
    end else begin
      gen_stops(pair_total());
      gen_msg(len);
    end
    frame_budget = 0;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 85) return 0;
    return $urandom_range(4, 65535);
  endfunction

  initial begin
    int sb, nfr, r;
    cur_stop_bits = 5'd20;
    cur_check     = 8'd0;
    cur_limit     = 7'd7;
    clear_extract();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // field extremes under reset settings
    frame_budget = 32'h4000_0000;
    push_item(1'b1, 24'h000000, 1023);
    push_item(1'b0, 24'hFFFFFF, -1024);
    push_item(1'b0, 24'h555555, 0);
    push_item(1'b0, 24'hAAAAAA, -1);
    push_item(1'b0, 24'h000001, 1);
    push_item(1'b0, 24'h800000, 2);
    push_item(1'b0, 24'h7FFFFF, -2);
    push_item(1'b0, 24'h123456, 7);
    push_item(1'b0, 24'hFEDCBA, -7);
    push_item(1'b0, 24'h0F0F0F, 8);
    push_item(1'b0, 24'hF0F0F0, -8);
    push_item(1'b0, 24'h00FF00, 512);
    push_item(1'b0, 24'hFF00FF, -513);
    push_item(1'b1, 24'h3C3C3C, 0);
    push_item(1'b0, 24'hC3C3C3, 3);
    wait_idle();

    set_config(3, 8'hA5, 5);
    gen_frame(2, 1'b0, 1'b0);
    gen_frame(1, 1'b1, 1'b0);
    gen_frame(3, 1'b0, 1'b0);
    wait_idle();

    // no stop bits
    set_config(0, 8'h00, 1);
    gen_frame(2, 1'b0, 1'b0);
    gen_frame(0, 1'b0, 1'b0);
    wait_idle();

    // stop positions wider than the position field
    set_config(31, 8'hFF, 1);
    gen_frame(2, 1'b0, 1'b0);
    wait_idle();

    set_config(2, 8'h07, 127);
    gen_frame(1, 1'b0, 1'b0);
    wait_idle();

    // even limit
    set_config(24, 8'h3C, 4);
    gen_frame(2, 1'b0, 1'b0);
    wait_idle();

    set_config(1, 8'h81, 2);
    gen_frame(0, 1'b0, 1'b0);
    gen_frame(65535, 1'b0, 1'b0);
    gen_frame(2, 1'b1, 1'b0);
    gen_frame(3, 1'b0, 1'b1);
    gen_frame(1, 1'b0, 1'b0);
    wait_idle();

    // limit lowered while stop positions are being read
    set_config(2, 8'h11, 9);
    frame_budget = 32'h4000_0000;
    gen_header(3, 1'b0);
    gen_stops(5);
    wait_idle();
    write_reg(CFG_COEFF_LIMIT, 8'd3);
    gen_msg(3);
    frame_budget = 0;
    wait_idle();

    while (real_cnt < ITEM_GOAL) begin
      r = $urandom_range(0, 19);
      if (r == 0) sb = 0;
      else if (r == 1) sb = $urandom_range(9, 31);
      else sb = $urandom_range(1, 6);
      set_config(sb, $urandom_range(0, 255), $urandom_range(1, 11));
      nfr = $urandom_range(2, 4);
      for (int f = 0; f < nfr; f++) begin
        gen_frame(pick_len(), $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 10);
        if ($urandom_range(0, 3) == 0) wait_idle();
      end
      wait_idle();
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
